@@ sv/cawf_pkg.sv @@
package cawf_pkg;

  localparam int unsigned ActionWidth = 5;
  localparam int unsigned NarrowWidth = 16;
  localparam int unsigned WideWidth   = 32;

  localparam logic [NarrowWidth-1:0] Mask16 = 16'hFFFF;
  localparam logic [WideWidth-1:0]   Mask32 = 32'hFFFF_FFFF;

  typedef enum logic [ActionWidth-1:0] {
    ActAdd    = 5'd0,
    ActAdc    = 5'd1,
    ActSub    = 5'd2,
    ActSbc    = 5'd3,
    ActEor    = 5'd4,
    ActOrr    = 5'd5,
    ActAnd    = 5'd6,
    ActAddw   = 5'd7,
    ActAdcw   = 5'd8,
    ActSubw   = 5'd9,
    ActSbcw   = 5'd10,
    ActAsr    = 5'd11,
    ActLsr    = 5'd12,
    ActLsl    = 5'd13,
    ActNot    = 5'd14,
    ActDec    = 5'd15,
    ActInc    = 5'd16,
    ActDecw   = 5'd17,
    ActIncw   = 5'd18,
    ActClrbit = 5'd19,
    ActSetbit = 5'd20
  } action_e;

  typedef struct packed {
    logic carry;
    logic zero;
    logic negative;
  } flags_t;

  typedef struct packed {
    logic [ActionWidth-1:0] action;
    logic [WideWidth-1:0]   operand_a;
    logic [NarrowWidth-1:0] operand_b;
  } op_t;

  typedef struct packed {
    logic [WideWidth-1:0] result;
    flags_t               flags;
  } res_t;

endpackage

@@ sv/cawf_in_reg.sv @@
module cawf_in_reg
  import cawf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  op_t  op_i,
  input  logic advance_i,
  output logic valid_o,
  output op_t  op_o
);

  logic valid_q, valid_d;
  op_t  op_q;
  logic load;

  // A new beat enters when the stage is empty or its item moves on this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q <= op_i;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

@@ sv/cawf_alu.sv @@
module cawf_alu
  import cawf_pkg::*;
(
  input  op_t    op_i,
  input  flags_t flags_i,
  output res_t   res_o
);

  logic [NarrowWidth-1:0] a16;
  logic [NarrowWidth-1:0] b16;
  logic [NarrowWidth-1:0] negb;
  logic [NarrowWidth-1:0] addend;
  logic                   cin;
  logic [NarrowWidth:0]   sum16;
  logic [WideWidth:0]     sum32;
  logic                   bit_in_range;
  logic [NarrowWidth-1:0] bit_mask;
  logic [WideWidth-1:0]   result;
  flags_t                 flags;
  logic                   upd_narrow;
  logic                   upd_wide;
  logic                   upd_carry_narrow;
  logic                   upd_carry_wide;
  logic [NarrowWidth-1:0] res16;
  action_e                act;

  assign act  = action_e'(op_i.action);
  assign a16  = op_i.operand_a[NarrowWidth-1:0];
  assign b16  = op_i.operand_b;
  assign negb = NarrowWidth'(~b16 + 16'd1);

  // One shared adder pair: the subtract forms add the two's complement of b.
  always_comb begin
    addend = b16;
    cin    = 1'b0;
    unique case (act)
      ActSub, ActSubw: addend = negb;
      ActSbc, ActSbcw: begin
        addend = negb;
        cin    = flags_i.carry;
      end
      ActAdc, ActAdcw: cin = flags_i.carry;
      default: addend = b16;
    endcase
  end

  assign sum16 = {1'b0, a16} + {1'b0, addend} + {{NarrowWidth{1'b0}}, cin};
  assign sum32 = {1'b0, op_i.operand_a} + {{(WideWidth-NarrowWidth+1){1'b0}}, addend}
               + {{WideWidth{1'b0}}, cin};

  assign bit_in_range = (b16[NarrowWidth-1:4] == '0);
  assign bit_mask     = bit_in_range ? (16'd1 << b16[3:0]) : '0;

  always_comb begin
    res16            = '0;
    result           = '0;
    upd_narrow       = 1'b0;
    upd_wide         = 1'b0;
    upd_carry_narrow = 1'b0;
    upd_carry_wide   = 1'b0;
    unique case (act)
      ActAdd, ActSub: begin
        res16 = sum16[NarrowWidth-1:0]; upd_narrow = 1'b1;
      end
      ActAdc, ActSbc: begin
        res16 = sum16[NarrowWidth-1:0]; upd_narrow = 1'b1; upd_carry_narrow = 1'b1;
      end
      ActEor:    begin res16 = a16 ^ b16;      upd_narrow = 1'b1; end
      ActOrr:    begin res16 = a16 | b16;      upd_narrow = 1'b1; end
      ActAnd:    begin res16 = a16 & b16;      upd_narrow = 1'b1; end
      ActAsr:    begin res16 = a16 >> 1;       upd_narrow = 1'b1; end
      ActLsr:    res16 = a16 >> 1;
      ActLsl:    res16 = (a16 << 1) & Mask16;
      ActNot:    begin res16 = ~a16;           upd_narrow = 1'b1; end
      ActDec:    begin res16 = a16 - 16'd1;    upd_narrow = 1'b1; end
      ActInc:    begin res16 = a16 + 16'd1;    upd_narrow = 1'b1; end
      ActClrbit: begin res16 = a16 & ~bit_mask; upd_narrow = 1'b1; end
      ActSetbit: begin res16 = a16 | bit_mask;  upd_narrow = 1'b1; end
      ActAddw, ActSubw: begin
        result = sum32[WideWidth-1:0]; upd_wide = 1'b1;
      end
      ActAdcw, ActSbcw: begin
        result = sum32[WideWidth-1:0]; upd_wide = 1'b1; upd_carry_wide = 1'b1;
      end
      ActDecw:   begin result = op_i.operand_a - 32'd1; upd_wide = 1'b1; end
      ActIncw:   begin result = op_i.operand_a + 32'd1; upd_wide = 1'b1; end
      default:   res16 = '0;
    endcase
    if (!upd_wide) begin
      result = {{(WideWidth-NarrowWidth){1'b0}}, res16};
    end
  end

  always_comb begin
    flags = flags_i;
    if (upd_narrow) begin
      flags.zero     = (res16 == '0);
      flags.negative = res16[NarrowWidth-1];
    end
    if (upd_wide) begin
      flags.zero     = (result == '0);
      flags.negative = result[WideWidth-1];
    end
    if (upd_carry_narrow) begin
      flags.carry = sum16[NarrowWidth];
    end
    if (upd_carry_wide) begin
      flags.carry = sum32[WideWidth];
    end
  end

  assign res_o.result = result & Mask32;
  assign res_o.flags  = flags;

endmodule

@@ sv/cawf_out_reg.sv @@
module cawf_out_reg
  import cawf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // The register can take a beat when it is empty or its beat leaves now.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/cpu_alu_with_flags_core.sv @@
// ALU with carry, zero and negative flags.
//
// Input channel: in_valid_i / in_ready_o carry one beat of action_i,
// operand_a_i and operand_b_i. Output channel: out_valid_o / out_ready_i
// carry one beat of result_o and the three flags as they stand after the
// operation. Every input beat yields exactly one output beat, in order.
//
// A beat accepted into the input register is computed by the ALU from
// there and lands in the result register once that register has room.
// Throughput is one beat per cycle while the receiver does not stall; the
// limit is the 33-bit add and flag logic between the two registers, and
// the flag registers that feed the next operation's carry in.
// Reset clears both valid bits and the three flags. When the receiver
// stalls, the result register holds its beat and the input register holds
// one more; in_ready_o drops only while both are full and out_ready_i is
// low. The flags advance when an item moves into the result register.
module cpu_alu_with_flags_core
  import cawf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ActionWidth-1:0] action_i,
  input  logic [WideWidth-1:0]   operand_a_i,
  input  logic [NarrowWidth-1:0] operand_b_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [WideWidth-1:0]   result_o,
  output logic                   carry_out_o,
  output logic                   zero_out_o,
  output logic                   negative_out_o
);

  op_t    op_in;
  op_t    op_stage;
  logic   stage_valid;
  logic   out_free;
  logic   advance;
  res_t   alu_res;
  res_t   out_res;
  flags_t flags_q;
  flags_t flags_d;

  assign op_in.action    = action_i;
  assign op_in.operand_a = operand_a_i;
  assign op_in.operand_b = operand_b_i;

  // The staged item is computed and moved on whenever the result register
  // has room for it.
  assign advance = stage_valid && out_free;

  cawf_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_in),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .op_o       (op_stage)
  );

  cawf_alu u_alu (
    .op_i    (op_stage),
    .flags_i (flags_q),
    .res_o   (alu_res)
  );

  // Architectural flags commit together with the result they belong to.
  assign flags_d = advance ? alu_res.flags : flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  cawf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (alu_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign result_o       = out_res.result;
  assign carry_out_o    = out_res.flags.carry;
  assign zero_out_o     = out_res.flags.zero;
  assign negative_out_o = out_res.flags.negative;

endmodule

@@ sv/cawf_checker.sv @@
module cawf_checker
  import cawf_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [ActionWidth-1:0] action_i,
  input logic [WideWidth-1:0]   operand_a_i,
  input logic [NarrowWidth-1:0] operand_b_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [WideWidth-1:0]   result_o,
  input logic                   carry_out_o,
  input logic                   zero_out_o,
  input logic                   negative_out_o
);

  // A waiting input beat stays offered with its payload unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(action_i)
      && $stable(operand_a_i) && $stable(operand_b_i))
    else $error("input beat changed while waiting");

  // A stalled output beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o)
      && $stable(carry_out_o) && $stable(zero_out_o) && $stable(negative_out_o))
    else $error("output beat changed while stalled");

  // Back pressure reaches the input only when both registers are full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled output");

  // An accepted beat reaches the output register unless the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // Without input beats the pipeline drains while out_ready_i stays high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && out_ready_i ##1 !in_valid_i && out_ready_i |=> !out_valid_o)
    else $error("output beat appeared from an empty pipeline");

endmodule

bind cpu_alu_with_flags_core cawf_checker u_cawf_checker (.*);
